@@ hdl/mnrg_pkg.sv @@
// Shared types, constants and helpers for the MIDI note range gate.
// Used by every module of the block except mnrg_ram; depends on nothing.
package mnrg_pkg;

    localparam int CHANNELS_DEF   = 16;
    localparam int KEYS_DEF       = 128;
    localparam int SWEEP_KEYS_DEF = 32;

    localparam int TBL_IDX_W   = 11;
    localparam int KEY_W       = 7;
    localparam int VEL_W       = 7;
    localparam int BASE_W      = 8;
    localparam int QUEUE_DEPTH = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_FILTER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_KEY        = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_KEY       = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE_SELECT    = 2'd3;

    localparam logic [1:0] MODE_BYPASS  = 2'd0;
    localparam logic [1:0] MODE_INCLUDE = 2'd1;
    localparam logic [1:0] MODE_EXCLUDE = 2'd2;

    localparam logic [3:0] NIB_NOTE_OFF = 4'h8;
    localparam logic [3:0] NIB_NOTE_ON  = 4'h9;
    localparam logic [3:0] CHAN_LAST    = 4'hf;
    localparam logic [KEY_W-1:0] KEY_MAX = 7'h7f;

    typedef enum logic [1:0] {
        OP_EMIT,
        OP_STORE_EMIT,
        OP_CLEAR_IF_HELD,
        OP_SWEEP
    } op_t;

    typedef enum logic [2:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_NOTE_CHECK,
        BK_SWEEP_READ,
        BK_SWEEP_CHECK,
        BK_SWEEP_END
    } back_state_t;

    typedef struct packed {
        logic [4:0]       channel_filter;
        logic [KEY_W-1:0] low_key;
        logic [KEY_W-1:0] high_key;
        logic [1:0]       mode_select;
    } cfg_t;

    typedef struct packed {
        op_t                  op;
        logic [31:0]          time_stamp;
        logic [1:0]           length;
        logic [7:0]           status;
        logic [7:0]           data_one;
        logic [7:0]           data_two;
        logic [TBL_IDX_W-1:0] idx;
        logic [VEL_W-1:0]     vel;
        logic [3:0]           chn;
        logic [BASE_W-1:0]    base;
    } cmd_t;

    function automatic logic key_passes(input logic [KEY_W-1:0] key, input cfg_t cfg);
        logic inside_range;
        inside_range = (key >= cfg.low_key) && (key <= cfg.high_key);
        return inside_range ^ (cfg.mode_select == MODE_EXCLUDE);
    endfunction

endpackage

@@ hdl/mnrg_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependencies.
module mnrg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hdl/mnrg_front.sv @@
// Front end: configuration registers, input acceptance and classification of items.
// Depends on mnrg_pkg.
module mnrg_front #(
    parameter int CHANNELS   = mnrg_pkg::CHANNELS_DEF,
    parameter int KEYS       = mnrg_pkg::KEYS_DEF,
    parameter int SWEEP_KEYS = mnrg_pkg::SWEEP_KEYS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mnrg_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mnrg_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                req_type,
    input  logic [31:0]                         time_stamp,
    input  logic [1:0]                          msg_length,
    input  logic [7:0]                          status_byte,
    input  logic [7:0]                          data_one,
    input  logic [7:0]                          data_two,
    input  logic [3:0]                          sweep_channel,
    input  logic [1:0]                          sweep_block,
    input  logic                                back_busy,
    input  logic                                q_full,
    output logic                                push,
    output mnrg_pkg::cmd_t                      cmd,
    output mnrg_pkg::cfg_t                      cfg
);

    mnrg_pkg::cfg_t cfg_reg;
    mnrg_pkg::cfg_t cfg_next;

    logic [3:0]                   mst;
    logic [3:0]                   chn;
    logic [4:0]                   cf_m1;
    logic [3:0]                   sel;
    logic                         is_note;
    logic                         chan_ok;
    logic                         gated;
    logic [mnrg_pkg::KEY_W-1:0]   key;
    logic [mnrg_pkg::VEL_W-1:0]   vel;
    logic                         note_on;
    logic                         storable;
    logic                         sweep_ok;
    logic [mnrg_pkg::TBL_IDX_W-1:0] idx_full;
    logic                         produce;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                mnrg_pkg::CFG_CHANNEL_FILTER: cfg_next.channel_filter = cfg_data[4:0];
                mnrg_pkg::CFG_LOW_KEY:        cfg_next.low_key        = cfg_data[6:0];
                mnrg_pkg::CFG_HIGH_KEY:       cfg_next.high_key       = cfg_data[6:0];
                mnrg_pkg::CFG_MODE_SELECT:    cfg_next.mode_select    = cfg_data[1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.channel_filter <= 5'd0;
            cfg_reg.low_key        <= '0;
            cfg_reg.high_key       <= mnrg_pkg::KEY_MAX;
            cfg_reg.mode_select    <= mnrg_pkg::MODE_INCLUDE;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign in_stall = back_busy || q_full;

    always_comb
    begin
        mst      = status_byte[7:4];
        chn      = status_byte[3:0];
        cf_m1    = cfg_reg.channel_filter - 5'd1;
        sel      = (cfg_reg.channel_filter > 5'd16) ? mnrg_pkg::CHAN_LAST : cf_m1[3:0];
        is_note  = (mst == mnrg_pkg::NIB_NOTE_ON) || (mst == mnrg_pkg::NIB_NOTE_OFF);
        chan_ok  = (cfg_reg.channel_filter == 5'd0) || (sel == chn);
        gated    = (msg_length == 2'd3) && is_note && chan_ok
                   && (cfg_reg.mode_select != mnrg_pkg::MODE_BYPASS);
        key      = data_one[6:0];
        vel      = data_two[6:0];
        note_on  = (mst == mnrg_pkg::NIB_NOTE_ON) && (vel != '0);
        storable = ({1'b0, chn} < 5'(CHANNELS)) && ({1'b0, key} < 8'(KEYS));
        sweep_ok = {1'b0, sweep_channel} < 5'(CHANNELS);
        idx_full = mnrg_pkg::TBL_IDX_W'(chn) * mnrg_pkg::TBL_IDX_W'(KEYS)
                   + mnrg_pkg::TBL_IDX_W'(key);

        cmd.op         = mnrg_pkg::OP_EMIT;
        cmd.time_stamp = time_stamp;
        cmd.length     = msg_length;
        cmd.status     = (msg_length > 2'd0) ? status_byte : 8'd0;
        cmd.data_one   = (msg_length > 2'd1) ? data_one : 8'd0;
        cmd.data_two   = (msg_length > 2'd2) ? data_two : 8'd0;
        cmd.idx        = idx_full;
        cmd.vel        = vel;
        cmd.chn        = sweep_channel;
        cmd.base       = mnrg_pkg::BASE_W'(sweep_block) * mnrg_pkg::BASE_W'(SWEEP_KEYS);
        produce        = 1'b1;

        priority if (req_type)
        begin
            cmd.op  = mnrg_pkg::OP_SWEEP;
            produce = sweep_ok;
        end
        else if (!gated)
        begin
            cmd.op = mnrg_pkg::OP_EMIT;
        end
        else if (note_on)
        begin
            produce = mnrg_pkg::key_passes(key, cfg_reg);
            cmd.op  = storable ? mnrg_pkg::OP_STORE_EMIT : mnrg_pkg::OP_EMIT;
        end
        else
        begin
            produce = storable;
            cmd.op  = mnrg_pkg::OP_CLEAR_IF_HELD;
        end
    end

    assign push = in_valid && !in_stall && produce;

endmodule

@@ hdl/mnrg_queue.sv @@
// Short command queue between front end and back end.
// Depends on mnrg_pkg for the command type.
module mnrg_queue #(
    parameter int DEPTH = mnrg_pkg::QUEUE_DEPTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  mnrg_pkg::cmd_t push_cmd,
    input  logic           pop,
    output mnrg_pkg::cmd_t head,
    output logic           empty,
    output logic           full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    mnrg_pkg::cmd_t   entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == CNT_W'(DEPTH));
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ hdl/mnrg_back.sv @@
// Back end: held-note table, table clearing, note-off lookup, release sweeps, result register.
// Depends on mnrg_pkg and mnrg_ram.
module mnrg_back #(
    parameter int CHANNELS   = mnrg_pkg::CHANNELS_DEF,
    parameter int KEYS       = mnrg_pkg::KEYS_DEF,
    parameter int SWEEP_KEYS = mnrg_pkg::SWEEP_KEYS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  mnrg_pkg::cfg_t cfg,
    input  mnrg_pkg::cmd_t head,
    input  logic           q_empty,
    output logic           pop,
    output logic           busy,
    output logic           out_valid,
    input  logic           out_stall,
    output logic [31:0]    out_time,
    output logic [1:0]     out_length,
    output logic [7:0]     out_status,
    output logic [7:0]     out_data_one,
    output logic [7:0]     out_data_two,
    output logic           last_of_run
);

    localparam int DEPTH  = CHANNELS * KEYS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(SWEEP_KEYS + 1);
    localparam int IW     = mnrg_pkg::TBL_IDX_W;
    localparam int BW     = mnrg_pkg::BASE_W;

    mnrg_pkg::back_state_t state_reg;
    mnrg_pkg::back_state_t state_next;
    mnrg_pkg::cmd_t        cur_reg;
    mnrg_pkg::cmd_t        cur_next;
    logic [ADDR_W-1:0]     addr_reg;
    logic [ADDR_W-1:0]     addr_next;
    logic [ADDR_W-1:0]     clr_reg;
    logic [ADDR_W-1:0]     clr_next;
    logic [CNT_W-1:0]      cnt_reg;
    logic [CNT_W-1:0]      cnt_next;
    logic                  pend_valid_reg;
    logic                  pend_valid_next;
    logic [mnrg_pkg::KEY_W-1:0] pend_key_reg;
    logic [mnrg_pkg::KEY_W-1:0] pend_key_next;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [31:0]           out_time_reg;
    logic [1:0]            out_length_reg;
    logic [7:0]            out_status_reg;
    logic [7:0]            out_data_one_reg;
    logic [7:0]            out_data_two_reg;
    logic                  last_reg;

    logic                  load;
    logic [31:0]           ld_time;
    logic [1:0]            ld_length;
    logic [7:0]            ld_status;
    logic [7:0]            ld_data_one;
    logic [7:0]            ld_data_two;
    logic                  ld_last;

    logic                  wr_en;
    logic [ADDR_W-1:0]     wr_addr;
    logic [mnrg_pkg::VEL_W-1:0] wr_data;
    logic                  rd_en;
    logic [ADDR_W-1:0]     rd_addr;
    logic [mnrg_pkg::VEL_W-1:0] rd_data;

    logic                  slot_free;
    logic [BW-1:0]         sweep_key;
    logic [IW-1:0]         sweep_idx;
    logic                  sweep_end;
    logic                  release_hit;
    logic [ADDR_W-1:0]     head_addr;

    mnrg_ram #(
        .WIDTH (mnrg_pkg::VEL_W),
        .DEPTH (DEPTH),
        .AW    (ADDR_W)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign slot_free   = !out_valid_reg || !out_stall;
    assign busy        = (state_reg == mnrg_pkg::BK_CLEAR);
    assign sweep_key   = cur_reg.base + BW'(cnt_reg);
    assign sweep_idx   = IW'(cur_reg.chn) * IW'(KEYS) + IW'(sweep_key);
    assign sweep_end   = (cnt_reg == CNT_W'(SWEEP_KEYS)) || (sweep_key >= BW'(KEYS))
                         || (sweep_key > BW'(mnrg_pkg::KEY_MAX));
    assign release_hit = (rd_data != '0)
                         && ((cfg.mode_select == mnrg_pkg::MODE_BYPASS)
                             || !mnrg_pkg::key_passes(sweep_key[6:0], cfg));
    assign head_addr   = head.idx[ADDR_W-1:0];

    always_comb
    begin
        state_next      = state_reg;
        cur_next        = cur_reg;
        addr_next       = addr_reg;
        clr_next        = clr_reg;
        cnt_next        = cnt_reg;
        pend_valid_next = pend_valid_reg;
        pend_key_next   = pend_key_reg;
        pop             = 1'b0;
        wr_en           = 1'b0;
        wr_addr         = addr_reg;
        wr_data         = '0;
        rd_en           = 1'b0;
        rd_addr         = addr_reg;
        load            = 1'b0;
        ld_time         = cur_reg.time_stamp;
        ld_length       = cur_reg.length;
        ld_status       = cur_reg.status;
        ld_data_one     = cur_reg.data_one;
        ld_data_two     = cur_reg.data_two;
        ld_last         = 1'b1;

        unique case (state_reg)
            mnrg_pkg::BK_CLEAR:
            begin
                wr_en    = 1'b1;
                wr_addr  = clr_reg;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == ADDR_W'(DEPTH - 1))
                begin
                    state_next = mnrg_pkg::BK_IDLE;
                end
            end
            mnrg_pkg::BK_IDLE:
            begin
                ld_time     = head.time_stamp;
                ld_length   = head.length;
                ld_status   = head.status;
                ld_data_one = head.data_one;
                ld_data_two = head.data_two;
                if (!q_empty)
                begin
                    unique case (head.op)
                        mnrg_pkg::OP_EMIT:
                        begin
                            if (slot_free)
                            begin
                                load = 1'b1;
                                pop  = 1'b1;
                            end
                        end
                        mnrg_pkg::OP_STORE_EMIT:
                        begin
                            if (slot_free)
                            begin
                                wr_en   = 1'b1;
                                wr_addr = head_addr;
                                wr_data = head.vel;
                                load    = 1'b1;
                                pop     = 1'b1;
                            end
                        end
                        mnrg_pkg::OP_CLEAR_IF_HELD:
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = head_addr;
                            addr_next  = head_addr;
                            cur_next   = head;
                            pop        = 1'b1;
                            state_next = mnrg_pkg::BK_NOTE_CHECK;
                        end
                        mnrg_pkg::OP_SWEEP:
                        begin
                            cur_next        = head;
                            cnt_next        = '0;
                            pend_valid_next = 1'b0;
                            pop             = 1'b1;
                            state_next      = mnrg_pkg::BK_SWEEP_READ;
                        end
                    endcase
                end
            end
            mnrg_pkg::BK_NOTE_CHECK:
            begin
                if (rd_data == '0)
                begin
                    state_next = mnrg_pkg::BK_IDLE;
                end
                else if (slot_free)
                begin
                    wr_en      = 1'b1;
                    load       = 1'b1;
                    state_next = mnrg_pkg::BK_IDLE;
                end
            end
            mnrg_pkg::BK_SWEEP_READ:
            begin
                if (sweep_end)
                begin
                    state_next = mnrg_pkg::BK_SWEEP_END;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = sweep_idx[ADDR_W-1:0];
                    addr_next  = sweep_idx[ADDR_W-1:0];
                    state_next = mnrg_pkg::BK_SWEEP_CHECK;
                end
            end
            mnrg_pkg::BK_SWEEP_CHECK:
            begin
                ld_time     = 32'd0;
                ld_length   = 2'd3;
                ld_status   = {mnrg_pkg::NIB_NOTE_OFF, cur_reg.chn};
                ld_data_one = {1'b0, pend_key_reg};
                ld_data_two = 8'd0;
                ld_last     = 1'b0;
                if (!release_hit)
                begin
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = mnrg_pkg::BK_SWEEP_READ;
                end
                else if (!pend_valid_reg || slot_free)
                begin
                    load            = pend_valid_reg;
                    wr_en           = 1'b1;
                    pend_key_next   = sweep_key[6:0];
                    pend_valid_next = 1'b1;
                    cnt_next        = cnt_reg + 1'b1;
                    state_next      = mnrg_pkg::BK_SWEEP_READ;
                end
            end
            mnrg_pkg::BK_SWEEP_END:
            begin
                ld_time     = 32'd0;
                ld_length   = 2'd3;
                ld_status   = {mnrg_pkg::NIB_NOTE_OFF, cur_reg.chn};
                ld_data_one = {1'b0, pend_key_reg};
                ld_data_two = 8'd0;
                if (!pend_valid_reg)
                begin
                    state_next = mnrg_pkg::BK_IDLE;
                end
                else if (slot_free)
                begin
                    load            = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = mnrg_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = mnrg_pkg::BK_IDLE;
            end
        endcase

        out_valid_next = load || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= mnrg_pkg::BK_CLEAR;
            clr_reg        <= '0;
            cnt_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_reg        <= clr_next;
            cnt_reg        <= cnt_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        addr_reg     <= addr_next;
        pend_key_reg <= pend_key_next;
        if (load)
        begin
            out_time_reg     <= ld_time;
            out_length_reg   <= ld_length;
            out_status_reg   <= ld_status;
            out_data_one_reg <= ld_data_one;
            out_data_two_reg <= ld_data_two;
            last_reg         <= ld_last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_time     = out_time_reg;
    assign out_length   = out_length_reg;
    assign out_status   = out_status_reg;
    assign out_data_one = out_data_one_reg;
    assign out_data_two = out_data_two_reg;
    assign last_of_run  = last_reg;

endmodule

@@ hdl/midi_note_range_gate_core.sv @@
// Top level of the MIDI note range gate: front end, command queue and back end.
// Depends on mnrg_pkg, mnrg_front, mnrg_queue, mnrg_back (and mnrg_ram below it).
//
//  channel  handshake            payload
//  cfg      cfg_valid/cfg_ready  cfg_index, cfg_data
//  in       in_valid/in_stall    req_type, time_stamp, msg_length, status_byte,
//                                data_one, data_two, sweep_channel, sweep_block
//  out      out_valid/out_stall  out_time, out_length, out_status, out_data_one,
//                                out_data_two, last_of_run
//
// Pass-through and note-on items are handled in the idle state; note-off items need a table read,
// then a check. A sweep does one read and one check on the table RAM for each of up to SWEEP_KEYS
// keys, then sends its last pending release, if any, in an end state. The front keeps taking items
// while the queue has room. After reset a clearing pass zeroes all CHANNELS*KEYS table entries;
// in_stall is high throughout, configuration writes are taken. Results wait in an output register under out_stall.
module midi_note_range_gate_core #(
    parameter int CHANNELS   = mnrg_pkg::CHANNELS_DEF,
    parameter int KEYS       = mnrg_pkg::KEYS_DEF,
    parameter int SWEEP_KEYS = mnrg_pkg::SWEEP_KEYS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [mnrg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mnrg_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            req_type,
    input  logic [31:0]                     time_stamp,
    input  logic [1:0]                      msg_length,
    input  logic [7:0]                      status_byte,
    input  logic [7:0]                      data_one,
    input  logic [7:0]                      data_two,
    input  logic [3:0]                      sweep_channel,
    input  logic [1:0]                      sweep_block,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [31:0]                     out_time,
    output logic [1:0]                      out_length,
    output logic [7:0]                      out_status,
    output logic [7:0]                      out_data_one,
    output logic [7:0]                      out_data_two,
    output logic                            last_of_run
);

    mnrg_pkg::cfg_t cfg;
    mnrg_pkg::cmd_t push_cmd;
    mnrg_pkg::cmd_t head;
    logic           push;
    logic           pop;
    logic           q_empty;
    logic           q_full;
    logic           back_busy;

    mnrg_front #(
        .CHANNELS   (CHANNELS),
        .KEYS       (KEYS),
        .SWEEP_KEYS (SWEEP_KEYS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .req_type      (req_type),
        .time_stamp    (time_stamp),
        .msg_length    (msg_length),
        .status_byte   (status_byte),
        .data_one      (data_one),
        .data_two      (data_two),
        .sweep_channel (sweep_channel),
        .sweep_block   (sweep_block),
        .back_busy     (back_busy),
        .q_full        (q_full),
        .push          (push),
        .cmd           (push_cmd),
        .cfg           (cfg)
    );

    mnrg_queue #(
        .DEPTH (mnrg_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .empty    (q_empty),
        .full     (q_full)
    );

    mnrg_back #(
        .CHANNELS   (CHANNELS),
        .KEYS       (KEYS),
        .SWEEP_KEYS (SWEEP_KEYS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .head         (head),
        .q_empty      (q_empty),
        .pop          (pop),
        .busy         (back_busy),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_time     (out_time),
        .out_length   (out_length),
        .out_status   (out_status),
        .out_data_one (out_data_one),
        .out_data_two (out_data_two),
        .last_of_run  (last_of_run)
    );

endmodule

@@ hdl/mnrg_checker.sv @@
// Port-level checks for midi_note_range_gate_core, bound to the top level.
// Depends on mnrg_pkg for the note-off code.
module mnrg_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] out_time,
    input logic [1:0]  out_length,
    input logic [7:0]  out_status,
    input logic [7:0]  out_data_one,
    input logic [7:0]  out_data_two,
    input logic        last_of_run
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_time) && $stable(out_status)
            && $stable(out_data_one) && $stable(last_of_run))
        else $error("stalled result changed");

    a_clear_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> in_stall)
        else $error("item taken during table clearing");

    a_run_is_release: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_of_run |-> out_length == 2'd3 && out_time == 32'd0
            && out_data_two == 8'd0 && out_status[7:4] == mnrg_pkg::NIB_NOTE_OFF
            && !out_data_one[7])
        else $error("non-final result is not a sweep release");

    a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_length == 2'd0 |-> out_status == 8'd0 && out_data_one == 8'd0)
        else $error("zero-length result carries bytes");

endmodule

bind midi_note_range_gate_core mnrg_checker u_mnrg_checker (.*);
